/* src/psc_pkg.sv */
`default_nettype none
package psc_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] RegOffset = 4'd0;
  localparam logic [CfgIdxW-1:0] RegSlope  = 4'd1;
  localparam logic [CfgIdxW-1:0] RegTemp   = 4'd2;
  localparam logic [CfgIdxW-1:0] RegCross  = 4'd3;

  // Pipeline depth from input beat to output register
  localparam int unsigned PipeDepth = 6;

  // Fixed-point constants
  localparam logic signed [10:0] TempRefCode  = 11'sd515;
  localparam logic signed [22:0] TempRecipQ16 = 23'sd3135928;  // 2^16*256/5.35
  localparam logic signed [15:0] TempRefQ8    = 16'sd6400;
  localparam logic signed [16:0] PresRecipQ16 = 17'sd41641;    // 2^16*650/1023
  localparam logic signed [19:0] PresBaseQ4   = 20'sd8000;

  // Calibration coefficients
  typedef struct packed {
    logic signed [15:0] a0;   // offset, 3 frac bits
    logic signed [15:0] b1;   // sensitivity, 13 frac bits
    logic signed [15:0] b2;   // temp offset, 14 frac bits
    logic signed [15:0] c12;  // cross term, 24 frac bits
  } coef_t;

  // Pipeline control shared by both paths
  typedef struct packed {
    logic en;  // all stages advance
  } pipe_ctrl_t;

endpackage
`default_nettype wire

/* src/psc_cfg_regs.sv */
`default_nettype none
module psc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [psc_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  wire logic [15:0]                   wr_data_i,
  output psc_pkg::coef_t                     coef_o
);
  import psc_pkg::*;

  coef_t coef_q;

  // Coefficient registers, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        RegOffset: coef_q.a0  <= wr_data_i;
        RegSlope:  coef_q.b1  <= wr_data_i;
        RegTemp:   coef_q.b2  <= wr_data_i;
        RegCross:  coef_q.c12 <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule
`default_nettype wire

/* src/psc_press_path.sv */
`default_nettype none
module psc_press_path (
  input  wire logic                 clk_i,
  input  wire psc_pkg::pipe_ctrl_t  ctrl_i,
  input  wire psc_pkg::coef_t       coef_i,
  input  wire logic [9:0]           p_i,
  input  wire logic [9:0]           t_i,
  output logic signed [18:0]        comp_o,
  output logic signed [18:0]        hpa_o
);
  import psc_pkg::*;

  // stage 1: cross and temp products
  logic signed [25:0] cross_q, b2t_q;
  logic [9:0]         p1_q;
  // stage 2: linear coefficient and offset terms
  logic signed [16:0] a1_d, a1_q;
  logic signed [26:0] off_d, off2_q;
  logic [9:0]         p2_q;
  // stage 3: main product
  logic signed [27:0] prod_q;
  logic signed [26:0] off3_q;
  // stage 4: compensated code
  logic signed [28:0] sum_d;
  logic signed [18:0] comp4_q;
  // stage 5: hPa product
  logic signed [35:0] hprod_q;
  logic signed [18:0] comp5_q;
  // stage 6: output
  logic signed [19:0] hsum_d;
  logic signed [18:0] comp6_q, hpa6_q;

  always_comb begin
    a1_d  = coef_i.b1 + 17'(cross_q >>> 11);
    off_d = 27'(b2t_q >>> 1) + 27'($signed({coef_i.a0, 10'd0}));
    sum_d = 29'(prod_q) + 29'(off3_q);
    hsum_d = 20'(hprod_q >>> 16) + PresBaseQ4;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      cross_q <= coef_i.c12 * $signed({1'b0, t_i});
      b2t_q   <= coef_i.b2 * $signed({1'b0, t_i});
      p1_q    <= p_i;

      a1_q    <= a1_d;
      off2_q  <= off_d;
      p2_q    <= p1_q;

      prod_q  <= a1_q * $signed({1'b0, p2_q});
      off3_q  <= off2_q;

      comp4_q <= 19'(sum_d >>> 9);

      hprod_q <= comp4_q * PresRecipQ16;
      comp5_q <= comp4_q;

      hpa6_q  <= 19'(hsum_d);
      comp6_q <= comp5_q;
    end
  end

  assign comp_o = comp6_q;
  assign hpa_o  = hpa6_q;

endmodule
`default_nettype wire

/* src/psc_temp_path.sv */
`default_nettype none
module psc_temp_path (
  input  wire logic                 clk_i,
  input  wire psc_pkg::pipe_ctrl_t  ctrl_i,
  input  wire logic [9:0]           t_i,
  output logic signed [15:0]        temp_o
);
  import psc_pkg::*;

  logic signed [10:0] diff_q;
  logic signed [33:0] tprod_q;
  logic signed [15:0] temp_q [4];

  // difference, reciprocal multiply, offset, then delay to match pressure
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      diff_q     <= TempRefCode - $signed({1'b0, t_i});
      tprod_q    <= diff_q * TempRecipQ16;
      temp_q[0]  <= 16'(tprod_q >>> 16) + TempRefQ8;
      temp_q[1]  <= temp_q[0];
      temp_q[2]  <= temp_q[1];
      temp_q[3]  <= temp_q[2];
    end
  end

  assign temp_o = temp_q[3];

endmodule
`default_nettype wire

/* src/pressure_sensor_compensation.sv */
// Throughput: one beat per cycle; the six-stage multiply pipeline stalls
// as a whole only while the output register holds a beat not yet taken.
// Reset clears the coefficient registers to zero and all stage valid bits;
// the configuration port is always ready.
`default_nettype none
module pressure_sensor_compensation (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input beat
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [23:0]                  s_axis_tdata_i,  // pressure_adc, temp_adc
  // output beat
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [55:0]                       m_axis_tdata_o,  // pressure_comp,
                                                             // temperature_q8,
                                                             // pressure_hpa_q4
  // configuration writes
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [psc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [15:0]                  cfg_data_i
);
  import psc_pkg::*;

  coef_t              coef;
  pipe_ctrl_t         ctrl;
  logic [PipeDepth-1:0] vld_q;
  logic signed [18:0] comp, hpa;
  logic signed [15:0] temp;

  assign cfg_ready_o = 1'b1;

  psc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .coef_o    (coef)
  );

  // Whole pipe moves unless the output beat is stalled
  assign ctrl.en         = !vld_q[PipeDepth-1] || m_axis_tready_i;
  assign s_axis_tready_o = ctrl.en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctrl.en) begin
      vld_q <= {vld_q[PipeDepth-2:0], s_axis_tvalid_i};
    end
  end

  psc_press_path u_press (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .coef_i (coef),
    .p_i    (s_axis_tdata_i[9:0]),
    .t_i    (s_axis_tdata_i[19:10]),
    .comp_o (comp),
    .hpa_o  (hpa)
  );

  psc_temp_path u_temp (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .t_i    (s_axis_tdata_i[19:10]),
    .temp_o (temp)
  );

  assign m_axis_tvalid_o = vld_q[PipeDepth-1];
  assign m_axis_tdata_o  = {2'b00, hpa, temp, comp};

endmodule
`default_nettype wire

/* src/psc_checker.sv */
`default_nettype none
module psc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid_i,
  input wire logic                         s_axis_tready_o,
  input wire logic [23:0]                  s_axis_tdata_i,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i,
  input wire logic [55:0]                  m_axis_tdata_o,
  input wire logic                         cfg_valid_i,
  input wire logic                         cfg_ready_o,
  input wire logic [psc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input wire logic [15:0]                  cfg_data_i
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat changed under stall");

  // input is refused only behind a stalled output beat
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // free-flowing output: an accepted beat shows up as a valid output beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) ##1 m_axis_tready_i ##1 m_axis_tready_i
      ##1 m_axis_tready_i ##1 m_axis_tready_i ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("beat lost in pipeline");

  // config port never refuses a write
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (.*);
`default_nettype wire
